[src/rsabf_pkg.sv]
// ---------------------------------------------------------------------------
// rsabf_pkg - range sensor alpha-beta filter shared definitions
// Transaction types, register map, control/status bundles and fixed-point
// constants used by the filter controller, datapath and register file.
// ---------------------------------------------------------------------------
package rsabf_pkg;

  // Distance fraction bits (1/256 cm at the default).
  localparam int FRAC_BITS  = 8;
  localparam int GAIN_SHIFT = 16;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;

  // Register reset values
  localparam logic [23:0] RST_SAMPLE_INTERVAL = 24'd66666;
  localparam logic [22:0] RST_MAX_RANGE       = 23'(55 << FRAC_BITS);
  localparam logic [15:0] RST_ALT_GAIN        = 16'd55450;
  localparam logic [19:0] RST_VEL_GAIN        = 20'd406547;
  localparam logic [23:0] RST_STALE_LIMIT     = 24'd250000;

  // Divide by one million: reciprocal 2^55 / 1e6 applied to the product
  // shifted down 20 bits, then at most three compare/subtract corrections.
  localparam longint unsigned US_PER_S   = 64'd1000000;
  localparam int              RECIP_SHIFT = 55;
  localparam logic [63:0]     RECIP_FULL  = (64'd1 << RECIP_SHIFT) / US_PER_S;
  localparam logic [35:0]     RECIP_M     = RECIP_FULL[35:0];
  localparam logic [23:0]     DIV_D       = 24'(US_PER_S);
  localparam logic [23:0]     DIV_2D      = 24'(2 * US_PER_S);
  localparam logic [23:0]     DIV_3D      = 24'(3 * US_PER_S);
  localparam logic [23:0]     HALF_D      = 24'(US_PER_S / 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_INTERVAL = 3'd0,
    CFG_MAX_RANGE       = 3'd1,
    CFG_ALT_GAIN        = 3'd2,
    CFG_VEL_GAIN        = 3'd3,
    CFG_STALE_LIMIT     = 3'd4
  } rsabf_cfg_idx_t;

  typedef struct packed {
    logic [23:0] sample_interval_us;
    logic [22:0] max_range;
    logic [15:0] alt_gain;
    logic [19:0] vel_gain;
    logic [23:0] stale_limit_us;
  } rsabf_cfg_t;

  typedef struct packed {
    logic [31:0]        now_us;
    logic               sensor_present;
    logic signed [23:0] range_reading;
  } rsabf_in_t;

  typedef struct packed {
    logic signed [23:0] est_altitude;
    logic signed [31:0] est_velocity;
    logic               interval_elapsed;
    logic               reading_accepted;
  } rsabf_out_t;

  // Controller -> datapath step enables
  typedef struct packed {
    logic load_in;    // capture input transaction, clear flags
    logic prep;       // latch dt, stale flag, |velocity|
    logic timer_upd;  // rate timer fired
    logic clear;      // sensor absent: zero estimator
    logic mul_pv;     // |pv| * dt + rounding half
    logic rec0;       // reciprocal partial product, low half
    logic rec1;       // reciprocal partial product, high half
    logic qest;       // quotient estimate
    logic rem;        // estimate * 1e6, low bits
    logic qfix;       // quotient correction
    logic pred;       // predicted altitude
    logic err;        // innovation
    logic gain_a;     // altitude gain products
    logic gain_v;     // velocity gain products
    logic corr_v;     // velocity correction, corrected altitude
    logic write;      // commit estimates
    logic load_out;   // load output register
  } rsabf_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic fire;
    logic present;
    logic in_gate;
  } rsabf_sts_t;

endpackage

[src/range_sensor_alpha_beta_filter_unit.sv]
// ---------------------------------------------------------------------------
// range_sensor_alpha_beta_filter_unit - range sensor alpha-beta filter
// Rate-limited, range-gated alpha-beta altitude/velocity estimator with
// saturating fixed-point arithmetic.
// ---------------------------------------------------------------------------
// One result transaction for every input transaction, in order. The unit takes
// one transaction at a time. A tick on which the rate timer does not fire, the
// sensor is absent or the reading falls outside (0, max_range] goes from the
// evaluation state straight to the sequencer's last state. A tick that runs
// the filter step first has the sequencer walk the arithmetic one registered
// operation per cycle: the velocity-times-dt product, two reciprocal partial
// products and a remainder correction for the divide by one million, then the
// shared gain multiplier for the altitude and velocity corrections. The result
// sits in an output register, so the next input is taken while a result still
// waits for out_ready; a second result then waits in the sequencer's last
// state, with in_ready low, until the output register frees. Configuration
// registers take effect immediately and should be written only while no
// transaction is in flight. No clearing pass after reset; the unit is ready
// once rst_n is released.
// ---------------------------------------------------------------------------
module range_sensor_alpha_beta_filter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transaction
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsabf_pkg::rsabf_in_t            in_data,
  // result transaction
  output logic                            out_valid,
  input  logic                            out_ready,
  output rsabf_pkg::rsabf_out_t           out_data,
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [rsabf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsabf_pkg::CFG_W-1:0]     cfg_wdata
);
  import rsabf_pkg::*;

  rsabf_cfg_t cfg;
  rsabf_cmd_t cmd;
  rsabf_sts_t sts;

  // register file: sample interval, range gate, gains, stale limit
  rsabf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: handshakes and step commands
  rsabf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // estimator state and arithmetic, output register
  rsabf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef SYNTH
  // one transaction in flight: acceptance drops ready on the next cycle
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  // a filter update can only happen on a tick where the timer fired
  a_accept_needs_fire : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.interval_elapsed || !out_data.reading_accepted))
    else $error("reading accepted without the rate timer firing");

  // the unit starts empty and ready after reset
  a_reset_state : assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("unit not idle after reset");

  // the output register is never reloaded while holding an untaken result
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
`endif

endmodule

[src/rsabf_cfg.sv]
// ---------------------------------------------------------------------------
// rsabf_cfg - filter configuration registers
// Write-only register file; indexes past the map are dropped.
// ---------------------------------------------------------------------------
module rsabf_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [rsabf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rsabf_pkg::CFG_W-1:0]           cfg_wdata,
  output rsabf_pkg::rsabf_cfg_t                 cfg
);
  import rsabf_pkg::*;

  rsabf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_interval_us <= RST_SAMPLE_INTERVAL;
      cfg_r.max_range          <= RST_MAX_RANGE;
      cfg_r.alt_gain           <= RST_ALT_GAIN;
      cfg_r.vel_gain           <= RST_VEL_GAIN;
      cfg_r.stale_limit_us     <= RST_STALE_LIMIT;
    end else if (cfg_wr_en) begin
      case (rsabf_cfg_idx_t'(cfg_index))
        CFG_SAMPLE_INTERVAL: cfg_r.sample_interval_us <= cfg_wdata;
        CFG_MAX_RANGE:       cfg_r.max_range          <= cfg_wdata[22:0];
        CFG_ALT_GAIN:        cfg_r.alt_gain           <= cfg_wdata[15:0];
        CFG_VEL_GAIN:        cfg_r.vel_gain           <= cfg_wdata[19:0];
        CFG_STALE_LIMIT:     cfg_r.stale_limit_us     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/rsabf_ctrl.sv]
// ---------------------------------------------------------------------------
// rsabf_ctrl - filter sequencer
// Walks one transaction through gate checks and, when they pass, the fixed-point
// filter step, then hands the result to the output register.
// ---------------------------------------------------------------------------
module rsabf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rsabf_pkg::rsabf_sts_t sts,
  output rsabf_pkg::rsabf_cmd_t cmd
);
  import rsabf_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'd1 << 0,
    S_EVAL   = 15'd1 << 1,
    S_MUL_PV = 15'd1 << 2,
    S_REC0   = 15'd1 << 3,
    S_REC1   = 15'd1 << 4,
    S_QEST   = 15'd1 << 5,
    S_REM    = 15'd1 << 6,
    S_QFIX   = 15'd1 << 7,
    S_PRED   = 15'd1 << 8,
    S_ERR    = 15'd1 << 9,
    S_GAIN_A = 15'd1 << 10,
    S_GAIN_V = 15'd1 << 11,
    S_CORR_V = 15'd1 << 12,
    S_WRITE  = 15'd1 << 13,
    S_DONE   = 15'd1 << 14
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.prep      = 1'b1;
        cmd.timer_upd = sts.fire;
        cmd.clear     = sts.fire && !sts.present;
        state_nxt     = (sts.fire && sts.present && sts.in_gate) ? S_MUL_PV : S_DONE;
      end
      S_MUL_PV: begin cmd.mul_pv = 1'b1; state_nxt = S_REC0;   end
      S_REC0:   begin cmd.rec0   = 1'b1; state_nxt = S_REC1;   end
      S_REC1:   begin cmd.rec1   = 1'b1; state_nxt = S_QEST;   end
      S_QEST:   begin cmd.qest   = 1'b1; state_nxt = S_REM;    end
      S_REM:    begin cmd.rem    = 1'b1; state_nxt = S_QFIX;   end
      S_QFIX:   begin cmd.qfix   = 1'b1; state_nxt = S_PRED;   end
      S_PRED:   begin cmd.pred   = 1'b1; state_nxt = S_ERR;    end
      S_ERR:    begin cmd.err    = 1'b1; state_nxt = S_GAIN_A; end
      S_GAIN_A: begin cmd.gain_a = 1'b1; state_nxt = S_GAIN_V; end
      S_GAIN_V: begin cmd.gain_v = 1'b1; state_nxt = S_CORR_V; end
      S_CORR_V: begin cmd.corr_v = 1'b1; state_nxt = S_WRITE;  end
      S_WRITE:  begin cmd.write  = 1'b1; state_nxt = S_DONE;   end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/rsabf_dp.sv]
// ---------------------------------------------------------------------------
// rsabf_dp - filter datapath
// Estimator state, rate timer, range gate and the fixed-point predict/correct
// arithmetic, one registered step per controller command.
// ---------------------------------------------------------------------------
module rsabf_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsabf_pkg::rsabf_cfg_t cfg,
  input  rsabf_pkg::rsabf_in_t  in_data,
  input  rsabf_pkg::rsabf_cmd_t cmd,
  output rsabf_pkg::rsabf_sts_t sts,
  output rsabf_pkg::rsabf_out_t out_data
);
  import rsabf_pkg::*;

  localparam logic signed [45:0] ALT_HI = 46'sd8388607;
  localparam logic signed [45:0] ALT_LO = -46'sd8388608;
  localparam logic signed [45:0] VEL_HI = 46'sd2147483647;
  localparam logic signed [45:0] VEL_LO = -46'sd2147483648;

  // captured transaction
  logic [31:0]        now_r;
  logic               present_r;
  logic signed [23:0] reading_r;

  // estimator state
  logic [31:0]        timer_r;
  logic [31:0]        last_acc_r;
  logic signed [23:0] alt_r;
  logic signed [31:0] vel_r;
  logic               fired_r;
  logic               accepted_r;

  // step registers
  logic [31:0]        pvmag_r;
  logic [23:0]        dt24_r;
  logic               neg_r;
  logic               stale_r;
  logic [55:0]        y_r;
  logic [53:0]        pp0_r;
  logic [53:0]        pp1_r;
  logic [35:0]        q0_r;
  logic [35:0]        q_r;
  logic [23:0]        rm_r;
  logic signed [37:0] pa_r;
  logic signed [39:0] e_r;
  logic [39:0]        plo_r;
  logic signed [40:0] phi_r;
  logic signed [44:0] corr_a_r;
  logic signed [44:0] corr_v_r;
  logic signed [45:0] na_r;
  rsabf_out_t         out_r;

  logic [31:0]        since_fire;
  logic [31:0]        dt;
  logic               stale;
  logic [31:0]        vel_mag;
  logic [55:0]        pv_prod;
  logic [17:0]        yh_half;
  logic [53:0]        rec_prod;
  logic [71:0]        rec_sum;
  logic [43:0]        rem_prod;
  logic [23:0]        rem;
  logic [1:0]         qcorr;
  logic signed [37:0] alt_ext;
  logic signed [37:0] q_ext;
  logic signed [39:0] err;
  logic [19:0]        gain;
  logic [19:0]        e_lo;
  logic signed [19:0] e_hi;
  logic [39:0]        plo;
  logic signed [40:0] phi;
  logic signed [60:0] psum;
  logic signed [44:0] pround;
  logic signed [31:0] pv;
  logic signed [45:0] nv;

  // round to nearest, ties away from zero, of v / 2^16
  function automatic logic signed [44:0] round_gain(input logic signed [60:0] v);
    logic signed [60:0] t;
    t = v + 61'sd32767 + (v[60] ? 61'sd0 : 61'sd1);
    return t[60:GAIN_SHIFT];
  endfunction

  function automatic logic signed [23:0] sat_alt(input logic signed [45:0] v);
    logic signed [45:0] c;
    c = v;
    if (v > ALT_HI) c = ALT_HI;
    if (v < ALT_LO) c = ALT_LO;
    return c[23:0];
  endfunction

  function automatic logic signed [31:0] sat_vel(input logic signed [45:0] v);
    logic signed [45:0] c;
    c = v;
    if (v > VEL_HI) c = VEL_HI;
    if (v < VEL_LO) c = VEL_LO;
    return c[31:0];
  endfunction

  // gate checks
  assign since_fire  = now_r - timer_r;
  assign sts.fire    = since_fire >= {8'd0, cfg.sample_interval_us};
  assign sts.present = present_r;
  assign sts.in_gate = !reading_r[23] && (reading_r != 24'sd0) &&
                       (reading_r[22:0] <= cfg.max_range);

  assign dt      = now_r - last_acc_r;
  assign stale   = dt >= {8'd0, cfg.stale_limit_us};
  assign vel_mag = vel_r[31] ? $unsigned(-vel_r) : $unsigned(vel_r);

  // |pv| * dt; dt fits 24 bits whenever pv is non-zero
  assign pv_prod = {24'd0, pvmag_r} * {32'd0, dt24_r};

  // reciprocal multiply shared by both halves of y >> 20
  assign yh_half  = cmd.rec1 ? y_r[55:38] : y_r[37:20];
  assign rec_prod = {36'd0, yh_half} * {18'd0, RECIP_M};
  assign rec_sum  = {pp1_r, 18'd0} + {18'd0, pp0_r};

  // remainder is below 4e6, so the low 24 bits are exact
  assign rem_prod = {20'd0, q0_r[23:0]} * {20'd0, DIV_D};
  assign rem      = y_r[23:0] - rm_r;
  assign qcorr    = {1'b0, rem >= DIV_D} + {1'b0, rem >= DIV_2D} + {1'b0, rem >= DIV_3D};

  assign alt_ext = 38'(alt_r);
  assign q_ext   = $signed({2'b00, q_r});
  assign err     = 40'(reading_r) - 40'(pa_r);

  // shared gain multiplier pair: innovation split into signed high / unsigned low
  assign gain  = cmd.gain_v ? cfg.vel_gain : {4'd0, cfg.alt_gain};
  assign e_lo  = e_r[19:0];
  assign e_hi  = e_r[39:20];
  assign plo   = {20'd0, gain} * {20'd0, e_lo};
  assign phi   = $signed({21'd0, gain}) * 41'(e_hi);

  assign psum   = $signed({phi_r, 20'd0}) + $signed({21'd0, plo_r});
  assign pround = round_gain(psum);

  assign pv = stale_r ? 32'sd0 : vel_r;
  assign nv = 46'(pv) + 46'(corr_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r    <= '0;
      last_acc_r <= '0;
      alt_r      <= '0;
      vel_r      <= '0;
      fired_r    <= 1'b0;
      accepted_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        fired_r    <= 1'b0;
        accepted_r <= 1'b0;
      end
      if (cmd.timer_upd) begin
        timer_r <= now_r;
        fired_r <= 1'b1;
      end
      if (cmd.clear) begin
        alt_r      <= '0;
        vel_r      <= '0;
        last_acc_r <= '0;
      end
      if (cmd.write) begin
        alt_r      <= sat_alt(na_r);
        vel_r      <= sat_vel(nv);
        last_acc_r <= now_r;
        accepted_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r     <= in_data.now_us;
      present_r <= in_data.sensor_present;
      reading_r <= in_data.range_reading;
    end
    if (cmd.prep) begin
      pvmag_r <= stale ? 32'd0 : vel_mag;
      dt24_r  <= dt[23:0];
      neg_r   <= !stale && vel_r[31];
      stale_r <= stale;
    end
    if (cmd.mul_pv) y_r   <= pv_prod + {32'd0, HALF_D};
    if (cmd.rec0)   pp0_r <= rec_prod;
    if (cmd.rec1)   pp1_r <= rec_prod;
    if (cmd.qest)   q0_r  <= rec_sum[70:35];
    if (cmd.rem)    rm_r  <= rem_prod[23:0];
    if (cmd.qfix)   q_r   <= q0_r + {34'd0, qcorr};
    if (cmd.pred)   pa_r  <= neg_r ? (alt_ext - q_ext) : (alt_ext + q_ext);
    if (cmd.err)    e_r   <= err;
    if (cmd.gain_a || cmd.gain_v) begin
      plo_r <= plo;
      phi_r <= phi;
    end
    if (cmd.gain_v) corr_a_r <= pround;
    if (cmd.corr_v) begin
      corr_v_r <= pround;
      na_r     <= 46'(pa_r) + 46'(corr_a_r);
    end
    if (cmd.load_out) begin
      out_r.est_altitude     <= alt_r;
      out_r.est_velocity     <= vel_r;
      out_r.interval_elapsed <= fired_r;
      out_r.reading_accepted <= accepted_r;
    end
  end

  assign out_data = out_r;

endmodule
